>>> src/bptc_pkg.sv
// Shared constants and types for the barometric compensation pipeline.
// No dependencies; imported by baro_pressure_temp_compensation.
`default_nettype none

package bptc_pkg;

    localparam int NSTG = 10;

    localparam int RAW_W  = 24;
    localparam int CAL_W  = 16;
    localparam int TEMP_W = 15;
    localparam int PRES_W = 17;
    localparam int IDX_W  = 3;

    localparam int TEMP_MIN = -4000;
    localparam int TEMP_MAX = 8500;
    localparam int PRES_MIN = 1000;
    localparam int PRES_MAX = 120000;

    localparam int TEMP_REF  = 2000;
    localparam int TEMP_VLOW = 3500;

    typedef enum logic [IDX_W-1:0] {
        CFG_SENS      = 3'd0,
        CFG_OFF       = 3'd1,
        CFG_SENS_TC   = 3'd2,
        CFG_OFF_TC    = 3'd3,
        CFG_REF_TEMP  = 3'd4,
        CFG_TEMP_SLP  = 3'd5
    } cfg_idx_t;

    typedef logic [NSTG-1:0] stg_vec_t;

endpackage : bptc_pkg

`default_nettype wire

>>> src/baro_pressure_temp_compensation.sv
// Top level: ten-stage pipeline for second-order pressure and temperature compensation.
// Depends on bptc_pkg for widths, limits and register indexes.
//
//  channel   dir   handshake                  payload
//  s_axis    in    s_axis_tvalid/tready       tdata: raw_pressure[23:0], raw_temp[47:24]
//  m_axis    out   m_axis_tvalid/tready       tdata: temp_centi[14:0], pressure_centi[31:15]
//  cfg       in    cfg_valid/cfg_ready        cfg_index, cfg_data (16 bits)
//
// One word per cycle enters and leaves while m_axis_tready does not stall the output.
// Each stage holds its word until the next stage frees, so empty stages fill while
// the output waits. Reset clears all valid bits and the calibration words to zero.
// The configuration channel is always ready; indexes above five are dropped.
`default_nettype none

module baro_pressure_temp_compensation
    import bptc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // raw_pressure[23:0], raw_temp[47:24]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // temp_centi[14:0], pressure_centi[31:15]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [CAL_W-1:0] cfg_data
);

    // calibration words
    logic [CAL_W-1:0] c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg;

    stg_vec_t v_reg;
    stg_vec_t en;

    // stage 0
    logic        [RAW_W-1:0] d1_0_reg;
    logic signed [24:0]      dt_0_reg;
    logic signed [24:0]      dt_next;
    // stage 1
    logic        [RAW_W-1:0] d1_1_reg;
    logic signed [40:0]      p6_1_reg, p4_1_reg, p3_1_reg;
    logic        [47:0]      dsq_1_reg;
    logic signed [40:0]      p6_next, p4_next, p3_next;
    logic signed [49:0]      dsq_full;
    // stage 2
    logic        [RAW_W-1:0] d1_2_reg;
    logic signed [18:0]      temp_2_reg, b_2_reg;
    logic signed [17:0]      a_2_reg;
    logic        [34:0]      off_2_reg;
    logic        [33:0]      sens_2_reg;
    logic        [16:0]      t2_2_reg;
    logic signed [17:0]      a_next;
    logic        [18:0]      temp_next, b_next;
    logic        [34:0]      off_next;
    logic        [33:0]      sens_next;
    // stage 3
    logic        [RAW_W-1:0] d1_3_reg;
    logic        [18:0]      temp_3_reg;
    logic                    low_3_reg, vlow_3_reg;
    logic        [34:0]      off_3_reg;
    logic        [33:0]      sens_3_reg;
    logic        [16:0]      t2_3_reg;
    logic        [34:0]      sq_3_reg, sq2_3_reg;
    logic signed [35:0]      sq_full;
    logic signed [37:0]      sq2_full;
    // stage 4
    logic        [RAW_W-1:0] d1_4_reg;
    logic        [TEMP_W-1:0] to_4_reg;
    logic        [34:0]      off_4_reg;
    logic        [33:0]      sens_4_reg;
    logic        [37:0]      off2_4_reg, sens2_4_reg;
    logic        [36:0]      sq5;
    logic        [37:0]      sq2x7, sq2x11;
    logic        [37:0]      off2_next, sens2_next;
    logic        [19:0]      tc;
    logic        [TEMP_W-1:0] to_next;
    // stage 5
    logic        [RAW_W-1:0] d1_5_reg;
    logic        [TEMP_W-1:0] to_5_reg;
    logic        [39:0]      offc_5_reg, sensc_5_reg;
    // stage 6
    logic        [TEMP_W-1:0] to_6_reg;
    logic        [39:0]      offc_6_reg;
    logic        [43:0]      pplo_6_reg;
    logic signed [44:0]      pphi_6_reg;
    logic        [43:0]      pplo_next;
    logic signed [44:0]      pphi_next;
    // stage 7
    logic        [TEMP_W-1:0] to_7_reg;
    logic        [39:0]      offc_7_reg;
    logic        [64:0]      prod_7_reg;
    // stage 8
    logic        [TEMP_W-1:0] to_8_reg;
    logic        [44:0]      diff_8_reg;
    // stage 9
    logic        [TEMP_W-1:0] to_9_reg;
    logic        [PRES_W-1:0] pres_9_reg;
    logic signed [29:0]      p_sh;
    logic        [PRES_W-1:0] pres_next;

    // handshake and stage enables
    always_comb
    begin
        en[NSTG-1] = !v_reg[NSTG-1] || m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = v_reg[NSTG-1];
    assign m_axis_tdata  = {pres_9_reg, to_9_reg};
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
            c5_reg <= '0;
            c6_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SENS:     c1_reg <= cfg_data;
                CFG_OFF:      c2_reg <= cfg_data;
                CFG_SENS_TC:  c3_reg <= cfg_data;
                CFG_OFF_TC:   c4_reg <= cfg_data;
                CFG_REF_TEMP: c5_reg <= cfg_data;
                CFG_TEMP_SLP: c6_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // datapath
    always_comb
    begin
        dt_next = $signed({1'b0, s_axis_tdata[47:24]} - {1'b0, c5_reg, 8'h00});

        p6_next  = 41'(dt_0_reg) * 41'($signed({1'b0, c6_reg}));
        p4_next  = 41'(dt_0_reg) * 41'($signed({1'b0, c4_reg}));
        p3_next  = 41'(dt_0_reg) * 41'($signed({1'b0, c3_reg}));
        dsq_full = 50'(dt_0_reg) * 50'(dt_0_reg);

        a_next    = $signed(p6_1_reg[40:23]);
        temp_next = {a_next[17], a_next} + 19'(TEMP_REF);
        b_next    = {a_next[17], a_next} + 19'(TEMP_VLOW);
        off_next  = {3'b000, c2_reg, 16'h0000} + {p4_1_reg[40], p4_1_reg[40:7]};
        sens_next = {3'b000, c1_reg, 15'h0000} + {p3_1_reg[40], p3_1_reg[40:8]};

        sq_full  = 36'(a_2_reg) * 36'(a_2_reg);
        sq2_full = 38'(b_2_reg) * 38'(b_2_reg);

        sq5    = {sq_3_reg, 2'b00} + {2'b00, sq_3_reg};
        sq2x7  = {sq2_3_reg, 3'b000} - {3'b000, sq2_3_reg};
        sq2x11 = {sq2_3_reg, 3'b000} + {2'b00, sq2_3_reg, 1'b0} + {3'b000, sq2_3_reg};
        off2_next  = '0;
        sens2_next = '0;
        if (low_3_reg)
        begin
            off2_next  = {2'b00, sq5[36:1]};
            sens2_next = {3'b000, sq5[36:2]};
            if (vlow_3_reg)
            begin
                off2_next  = off2_next + sq2x7;
                sens2_next = sens2_next + {1'b0, sq2x11[37:1]};
            end
        end
        tc = {temp_3_reg[18], temp_3_reg} - (low_3_reg ? {3'b000, t2_3_reg} : 20'd0);
        if ($signed(tc) < TEMP_MIN)
        begin
            to_next = TEMP_W'(TEMP_MIN);
        end
        else if ($signed(tc) > TEMP_MAX)
        begin
            to_next = TEMP_W'(TEMP_MAX);
        end
        else
        begin
            to_next = tc[TEMP_W-1:0];
        end

        pplo_next = 44'(d1_5_reg) * 44'(sensc_5_reg[19:0]);
        pphi_next = 45'($signed({1'b0, d1_5_reg})) * 45'($signed(sensc_5_reg[39:20]));

        p_sh = $signed(diff_8_reg[44:15]);
        if (p_sh < PRES_MIN)
        begin
            pres_next = PRES_W'(PRES_MIN);
        end
        else if (p_sh > PRES_MAX)
        begin
            pres_next = PRES_W'(PRES_MAX);
        end
        else
        begin
            pres_next = p_sh[PRES_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            d1_0_reg <= s_axis_tdata[23:0];
            dt_0_reg <= dt_next;
        end
        if (en[1])
        begin
            d1_1_reg  <= d1_0_reg;
            p6_1_reg  <= p6_next;
            p4_1_reg  <= p4_next;
            p3_1_reg  <= p3_next;
            dsq_1_reg <= dsq_full[47:0];
        end
        if (en[2])
        begin
            d1_2_reg   <= d1_1_reg;
            a_2_reg    <= a_next;
            temp_2_reg <= $signed(temp_next);
            b_2_reg    <= $signed(b_next);
            off_2_reg  <= off_next;
            sens_2_reg <= sens_next;
            t2_2_reg   <= dsq_1_reg[47:31];
        end
        if (en[3])
        begin
            d1_3_reg   <= d1_2_reg;
            temp_3_reg <= temp_2_reg;
            low_3_reg  <= a_2_reg[17];
            vlow_3_reg <= b_2_reg[18];
            off_3_reg  <= off_2_reg;
            sens_3_reg <= sens_2_reg;
            t2_3_reg   <= t2_2_reg;
            sq_3_reg   <= sq_full[34:0];
            sq2_3_reg  <= sq2_full[34:0];
        end
        if (en[4])
        begin
            d1_4_reg    <= d1_3_reg;
            to_4_reg    <= to_next;
            off_4_reg   <= off_3_reg;
            sens_4_reg  <= sens_3_reg;
            off2_4_reg  <= off2_next;
            sens2_4_reg <= sens2_next;
        end
        if (en[5])
        begin
            d1_5_reg    <= d1_4_reg;
            to_5_reg    <= to_4_reg;
            offc_5_reg  <= {{5{off_4_reg[34]}}, off_4_reg} - {2'b00, off2_4_reg};
            sensc_5_reg <= {{6{sens_4_reg[33]}}, sens_4_reg} - {2'b00, sens2_4_reg};
        end
        if (en[6])
        begin
            to_6_reg   <= to_5_reg;
            offc_6_reg <= offc_5_reg;
            pplo_6_reg <= pplo_next;
            pphi_6_reg <= pphi_next;
        end
        if (en[7])
        begin
            to_7_reg   <= to_6_reg;
            offc_7_reg <= offc_6_reg;
            prod_7_reg <= {pphi_6_reg, 20'h00000} + {21'h0, pplo_6_reg};
        end
        if (en[8])
        begin
            to_8_reg   <= to_7_reg;
            diff_8_reg <= {prod_7_reg[64], prod_7_reg[64:21]}
                        - {{5{offc_7_reg[39]}}, offc_7_reg};
        end
        if (en[9])
        begin
            to_9_reg   <= to_8_reg;
            pres_9_reg <= pres_next;
        end
    end

`ifndef SYNTHESIS
    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[14:0]) >= TEMP_MIN
                           && $signed(m_axis_tdata[14:0]) <= TEMP_MAX))
        else $error("temperature out of range");

    a_pres_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[31:15] >= PRES_W'(PRES_MIN)
                           && m_axis_tdata[31:15] <= PRES_W'(PRES_MAX)))
        else $error("pressure out of range");

    a_full_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (&v_reg))
        else $error("input stalled with an empty stage");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> v_reg[0])
        else $error("accepted word missing from first stage");
`endif

endmodule : baro_pressure_temp_compensation

`default_nettype wire

>>> dv/baro_pressure_temp_compensation_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for baro_pressure_temp_compensation: directed and random raw
// reading pairs under several calibrations, each result checked against a predictor.
// Depends on bptc_pkg and the compensation top level.

module baro_pressure_temp_compensation_tb;
    import bptc_pkg::*;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_centi;
        logic [PRES_W-1:0]        pressure_centi;
    } reading_t;

    localparam logic [IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam longint VERY_COLD = -1500;
    localparam longint RAW_TOP = 64'd16777215;
    localparam logic [RAW_W-1:0] RAW_MAX = {RAW_W{1'b1}};
    localparam logic [CAL_W-1:0] CAL_MAX = {CAL_W{1'b1}};

    localparam logic [CAL_W-1:0] TYP_SENS     = 16'd40127;
    localparam logic [CAL_W-1:0] TYP_OFF      = 16'd36924;
    localparam logic [CAL_W-1:0] TYP_SENS_TC  = 16'd23317;
    localparam logic [CAL_W-1:0] TYP_OFF_TC   = 16'd23282;
    localparam logic [CAL_W-1:0] TYP_REF_TEMP = 16'd33464;
    localparam logic [CAL_W-1:0] TYP_TEMP_SLP = 16'd28312;

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [47:0]        s_axis_tdata;   // raw_pressure[23:0], raw_temp[47:24]
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [31:0]        m_axis_tdata;   // temp_centi[14:0], pressure_centi[31:15]
    logic               cfg_valid;
    logic               cfg_ready;
    logic [IDX_W-1:0]   cfg_index;
    logic [CAL_W-1:0]   cfg_data;

    logic [CAL_W-1:0]   cal_word [0:5];
    reading_t           expected_readings [$];
    reading_t           want_reading;
    int                 mismatches;
    int                 src_idle_pct;
    int                 sink_idle_pct;

    baro_pressure_temp_compensation dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic reading_t compensate(input logic [RAW_W-1:0] raw_p,
                                            input logic [RAW_W-1:0] raw_t);
        longint d1, d2, c1, c2, c3, c4, c5, c6;
        longint dt, temp, off, sens, t2, off2, sens2, dev_sq, cold_sq, pres;
        reading_t r;
        d1 = longint'(raw_p);
        d2 = longint'(raw_t);
        c1 = longint'(cal_word[CFG_SENS]);
        c2 = longint'(cal_word[CFG_OFF]);
        c3 = longint'(cal_word[CFG_SENS_TC]);
        c4 = longint'(cal_word[CFG_OFF_TC]);
        c5 = longint'(cal_word[CFG_REF_TEMP]);
        c6 = longint'(cal_word[CFG_TEMP_SLP]);
        dt   = d2 - (c5 <<< 8);
        temp = TEMP_REF + ((dt * c6) >>> 23);
        off  = (c2 <<< 16) + ((c4 * dt) >>> 7);
        sens = (c1 <<< 15) + ((c3 * dt) >>> 8);
        t2    = 0;
        off2  = 0;
        sens2 = 0;
        if (temp < TEMP_REF)
        begin
            dev_sq = (temp - TEMP_REF) * (temp - TEMP_REF);
            t2     = (dt * dt) >>> 31;
            off2   = (5 * dev_sq) >>> 1;
            sens2  = (5 * dev_sq) >>> 2;
            if (temp < VERY_COLD)
            begin
                cold_sq = (temp - VERY_COLD) * (temp - VERY_COLD);
                off2    = off2 + 7 * cold_sq;
                sens2   = sens2 + ((11 * cold_sq) >>> 1);
            end
        end
        temp = temp - t2;
        off  = off - off2;
        sens = sens - sens2;
        pres = (((d1 * sens) >>> 21) - off) >>> 15;
        if (temp < TEMP_MIN)
            temp = TEMP_MIN;
        else if (temp > TEMP_MAX)
            temp = TEMP_MAX;
        if (pres < PRES_MIN)
            pres = PRES_MIN;
        else if (pres > PRES_MAX)
            pres = PRES_MAX;
        r.temp_centi     = temp[TEMP_W-1:0];
        r.pressure_centi = pres[PRES_W-1:0];
        return r;
    endfunction

    always @(negedge clk)
    begin
        if (rst_n)
            m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_readings.size() == 0)
            begin
                $display("%0t: unexpected word: expected none, actual %h", $time, m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want_reading = expected_readings.pop_front();
                if (m_axis_tdata[14:0] !== want_reading.temp_centi)
                begin
                    $display("%0t: temp_centi: expected %0d, actual %0d", $time,
                             want_reading.temp_centi, $signed(m_axis_tdata[14:0]));
                    mismatches++;
                end
                if (m_axis_tdata[31:15] !== want_reading.pressure_centi)
                begin
                    $display("%0t: pressure_centi: expected %0d, actual %0d", $time,
                             want_reading.pressure_centi, m_axis_tdata[31:15]);
                    mismatches++;
                end
            end
        end
    end

    task automatic send_reading(input logic [RAW_W-1:0] raw_p, input logic [RAW_W-1:0] raw_t);
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {raw_t, raw_p};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_readings.push_back(compensate(raw_p, raw_t));
    endtask

    // hold off the source until the pipeline is empty
    task automatic drain_pipeline;
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (NSTG + 2) @(posedge clk);
    endtask

    task automatic write_register(input logic [IDX_W-1:0] idx, input logic [CAL_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx <= CFG_TEMP_SLP)
            cal_word[idx] = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_calibration(input logic [CAL_W-1:0] c1, input logic [CAL_W-1:0] c2,
                                    input logic [CAL_W-1:0] c3, input logic [CAL_W-1:0] c4,
                                    input logic [CAL_W-1:0] c5, input logic [CAL_W-1:0] c6);
        drain_pipeline();
        write_register(CFG_SENS, c1);
        write_register(CFG_OFF, c2);
        write_register(CFG_SENS_TC, c3);
        write_register(CFG_OFF_TC, c4);
        write_register(CFG_REF_TEMP, c5);
        write_register(CFG_TEMP_SLP, c6);
    endtask

    task automatic load_random_calibration;
        if ($urandom_range(0, 1) == 1)
            load_calibration(CAL_W'(TYP_SENS + $urandom_range(0, 8000) - 4000),
                             CAL_W'(TYP_OFF + $urandom_range(0, 8000) - 4000),
                             CAL_W'(TYP_SENS_TC + $urandom_range(0, 8000) - 4000),
                             CAL_W'(TYP_OFF_TC + $urandom_range(0, 8000) - 4000),
                             CAL_W'(TYP_REF_TEMP + $urandom_range(0, 8000) - 4000),
                             CAL_W'(TYP_TEMP_SLP + $urandom_range(0, 8000) - 4000));
        else
            load_calibration(CAL_W'($urandom_range(0, 65535)), CAL_W'($urandom_range(0, 65535)),
                             CAL_W'($urandom_range(0, 65535)), CAL_W'($urandom_range(0, 65535)),
                             CAL_W'($urandom_range(0, 65535)), CAL_W'($urandom_range(0, 65535)));
        if ($urandom_range(0, 3) == 0)
            write_register($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO,
                           CAL_W'($urandom_range(0, 65535)));
    endtask

    // sweep raw_temp around the reference point, and at times across its full range, so every branch is hit
    task automatic send_random_reading;
        longint center, spread, raw_t;
        logic [RAW_W-1:0] raw_p;
        if ($urandom_range(0, 9) < 7)
        begin
            center = longint'(cal_word[CFG_REF_TEMP]);
            center = center * 256;
            spread = longint'(1) << $urandom_range(6, 23);
            raw_t  = center + $urandom_range(0, 2 * spread) - spread;
            if (raw_t < 0)
                raw_t = 0;
            if (raw_t > RAW_TOP)
                raw_t = RAW_TOP;
            if ($urandom_range(0, 3) == 0)
                raw_p = RAW_W'($urandom());
            else
                raw_p = RAW_W'($urandom_range(4_000_000, 12_000_000));
        end
        else
        begin
            raw_t = longint'($urandom_range(0, RAW_TOP));
            raw_p = RAW_W'($urandom());
        end
        send_reading(raw_p, raw_t[RAW_W-1:0]);
    endtask

    task automatic test_unset_calibration;
        send_reading('0, '0);
        send_reading(RAW_MAX, RAW_MAX);
        send_reading(24'd9085466, 24'd8569150);
    endtask

    task automatic test_spare_index;
        drain_pipeline();
        write_register(CFG_SPARE_LO, CAL_MAX);
        write_register(CFG_SPARE_HI, 16'h5A5A);
        send_reading(24'd9085466, 24'd8569150);
    endtask

    task automatic test_typical_calibration;
        load_calibration(TYP_SENS, TYP_OFF, TYP_SENS_TC, TYP_OFF_TC, TYP_REF_TEMP, TYP_TEMP_SLP);
        send_reading(24'd9085466, 24'd8569150);
        send_reading(24'd9085466, 24'd8566784);
        send_reading('0, 24'd8569150);
        send_reading(RAW_MAX, 24'd8569150);
    endtask

    task automatic test_cold_branches;
        send_reading(24'd9085466, 24'd8566783);
        send_reading(24'd9085466, 24'd7974204);
        send_reading(24'd9085466, 24'd7529764);
        send_reading(24'd9085466, 24'd7529763);
        send_reading(24'd9085466, 24'd7085334);
        send_reading(24'd9085466, '0);
        send_reading(24'd9085466, RAW_MAX);
    endtask

    task automatic test_saturated_calibration;
        load_calibration(CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX);
        send_reading('0, '0);
        send_reading(RAW_MAX, RAW_MAX);
        send_reading(RAW_MAX, '0);
        send_reading('0, RAW_MAX);
    endtask

    task automatic test_random(input int n, input int src_pct, input int sink_pct);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        for (int g = 0; g < 5; g++)
        begin
            load_random_calibration();
            for (int i = 0; i < n / 5; i++)
                send_random_reading();
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        mismatches    = 0;
        src_idle_pct  = 35;
        sink_idle_pct = 77;
        foreach (cal_word[i])
            cal_word[i] = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_unset_calibration();
        test_spare_index();
        test_typical_calibration();
        test_cold_branches();
        test_saturated_calibration();
        test_random(170, 35, 77);
        test_random(170, 77, 35);
        test_random(170, 0, 0);

        drain_pipeline();
        if (mismatches == 0 && expected_readings.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
